// ----- hdl/unique_element_filter_macros.svh -----
// assertion helpers for the unique element filter
`ifndef UNIQUE_ELEMENT_FILTER_MACROS_SVH
`define UNIQUE_ELEMENT_FILTER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define UEF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uef check failed");
// next-cycle implication
`define UEF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uef check failed");
`else
`define UEF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define UEF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/uef_pkg.sv -----
package uef_pkg;

  localparam int VALUE_W          = 10;
  localparam int DEF_VALUE_RANGE  = 1024;
  localparam int DEF_MAX_ELEMENTS = 16;

  typedef enum logic [3:0] {
    ST_CLR_ALL,
    ST_IDLE,
    ST_SLOT,
    ST_HRD,
    ST_WALK_BRD,
    ST_WALK_HRD,
    ST_WALK_CHK,
    ST_FLUSH,
    ST_ZAP_BRD,
    ST_ZAP_WR
  } uef_state_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic               none;
    logic               last;
  } push_t;

endpackage

// ----- hdl/uef_slot.sv -----
module uef_slot #(
  parameter int VALUE_RANGE = 1024,
  localparam int SLOT_W = $clog2(VALUE_RANGE)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [uef_pkg::VALUE_W-1:0] value,
  output logic [SLOT_W-1:0]           slot,
  output logic                        done
);
  import uef_pkg::*;

  // quotient as (value * RECIP) >> MUL_SH, exact over the whole value field
  localparam int     MUL_SH  = VALUE_W + SLOT_W;
  localparam int     RECIP_W = VALUE_W + 1;
  localparam int     PROD_W  = VALUE_W + RECIP_W;
  localparam longint RECIP_L = ((longint'(1) << MUL_SH) + longint'(VALUE_RANGE) - longint'(1))
                               / longint'(VALUE_RANGE);
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_L);
  // quotient is zero whenever the range exceeds this width
  localparam logic [RECIP_W-1:0] RANGE_LO = RECIP_W'(VALUE_RANGE);

  logic [VALUE_W-1:0]        v_q;
  logic [VALUE_W-1:0]        q;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W-1:0]         back;
  logic [VALUE_W-1:0]        r;
  logic                      busy;
  logic [SLOT_W+VALUE_W-1:0] r_ext;

  assign prod = PROD_W'(value) * PROD_W'(RECIP);
  assign back = PROD_W'(q) * PROD_W'(RANGE_LO);

  // two steps: quotient, then remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      v_q  <= value;
      q    <= VALUE_W'(prod >> MUL_SH);
      busy <= 1'b1;
    end else if (busy) begin
      r    <= v_q - back[VALUE_W-1:0];
      busy <= 1'b0;
    end
  end

  assign r_ext = {{SLOT_W{1'b0}}, r};
  assign slot  = r_ext[SLOT_W-1:0];
  assign done  = !busy;

endmodule

// ----- hdl/uef_hist.sv -----
module uef_hist #(
  parameter int VALUE_RANGE = 1024,
  localparam int SLOT_W = $clog2(VALUE_RANGE)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] raddr,
  output logic [1:0]        rdata,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] waddr,
  input  logic [1:0]        wdata
);

  logic [1:0] mem [VALUE_RANGE];

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[raddr];
  end

endmodule

// ----- hdl/uef_buf.sv -----
module uef_buf #(
  parameter int MAX_ELEMENTS = 16,
  parameter int SLOT_W = 10,
  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            waddr,
  input  logic [SLOT_W-1:0]           wslot,
  input  logic [uef_pkg::VALUE_W-1:0] wvalue,
  input  logic                        rd_en,
  input  logic [IDX_W-1:0]            raddr,
  output logic [SLOT_W-1:0]           rslot,
  output logic [uef_pkg::VALUE_W-1:0] rvalue
);
  import uef_pkg::*;

  // each entry keeps the element and its histogram slot
  logic [SLOT_W+VALUE_W-1:0] mem [MAX_ELEMENTS];

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= {wslot, wvalue};
  end

  always_ff @(posedge clk) begin
    if (rd_en) {rslot, rvalue} <= mem[raddr];
  end

endmodule

// ----- hdl/uef_ctrl.sv -----
module uef_ctrl #(
  parameter int VALUE_RANGE = 1024,
  parameter int MAX_ELEMENTS = 16,
  localparam int SLOT_W = $clog2(VALUE_RANGE),
  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [uef_pkg::VALUE_W-1:0] in_value,
  input  logic                        in_end,
  output logic                        in_stall,
  output logic                        slot_start,
  input  logic                        slot_done,
  input  logic [SLOT_W-1:0]           slot,
  output logic                        hist_rd_en,
  output logic [SLOT_W-1:0]           hist_raddr,
  input  logic [1:0]                  hist_rdata,
  output logic                        hist_wr_en,
  output logic [SLOT_W-1:0]           hist_waddr,
  output logic [1:0]                  hist_wdata,
  output logic                        buf_wr_en,
  output logic [IDX_W-1:0]            buf_waddr,
  output logic [SLOT_W-1:0]           buf_wslot,
  output logic [uef_pkg::VALUE_W-1:0] buf_wvalue,
  output logic                        buf_rd_en,
  output logic [IDX_W-1:0]            buf_raddr,
  input  logic [SLOT_W-1:0]           buf_rslot,
  input  logic [uef_pkg::VALUE_W-1:0] buf_rvalue,
  input  logic                        out_free,
  output uef_pkg::push_t              push
);
  import uef_pkg::*;

  uef_state_t         state, state_next;
  logic [SLOT_W-1:0]  clr_idx;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   idx;
  logic [VALUE_W-1:0] cur_value;
  logic               cur_last;
  logic [VALUE_W-1:0] pend;
  logic               pend_valid;

  logic [CNT_W-1:0]   count_inc;
  logic [CNT_W-1:0]   idx_inc;
  logic               closing;
  logic               last_elem;
  logic               cand;
  logic               walk_go;

  assign count_inc = count + CNT_W'(1);
  assign idx_inc   = CNT_W'(idx) + CNT_W'(1);
  assign closing   = cur_last || (count_inc == CNT_W'(MAX_ELEMENTS));
  assign last_elem = (idx_inc == count);
  assign cand      = (hist_rdata == 2'd1);
  // a new candidate must first push out the held one
  assign walk_go   = !(cand && pend_valid) || out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLR_ALL:  if (clr_idx == SLOT_W'(VALUE_RANGE - 1)) state_next = ST_IDLE;
      ST_IDLE:     if (in_valid) state_next = ST_SLOT;
      ST_SLOT:     if (slot_done) state_next = ST_HRD;
      ST_HRD:      state_next = closing ? ST_WALK_BRD : ST_IDLE;
      ST_WALK_BRD: state_next = ST_WALK_HRD;
      ST_WALK_HRD: state_next = ST_WALK_CHK;
      ST_WALK_CHK: if (walk_go) state_next = last_elem ? ST_FLUSH : ST_WALK_BRD;
      ST_FLUSH:    if (out_free) state_next = ST_ZAP_BRD;
      ST_ZAP_BRD:  state_next = ST_ZAP_WR;
      ST_ZAP_WR:   if (last_elem) state_next = ST_IDLE;
                   else state_next = ST_ZAP_BRD;
      default:     state_next = ST_CLR_ALL;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    slot_start = 1'b0;
    hist_rd_en = 1'b0;
    hist_raddr = slot;
    hist_wr_en = 1'b0;
    hist_waddr = slot;
    hist_wdata = 2'd0;
    buf_wr_en  = 1'b0;
    buf_waddr  = count[IDX_W-1:0];
    buf_wslot  = slot;
    buf_wvalue = cur_value;
    buf_rd_en  = 1'b0;
    buf_raddr  = idx;
    push       = '0;
    case (state)
      ST_CLR_ALL: begin
        hist_wr_en = 1'b1;
        hist_waddr = clr_idx;
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        slot_start = in_valid;
      end
      ST_SLOT: begin
        hist_rd_en = slot_done;
      end
      ST_HRD: begin
        hist_wr_en = 1'b1;
        hist_wdata = (hist_rdata >= 2'd2) ? 2'd2 : hist_rdata + 2'd1;
        buf_wr_en  = 1'b1;
      end
      ST_WALK_BRD: begin
        buf_rd_en = 1'b1;
      end
      ST_WALK_HRD: begin
        hist_rd_en = 1'b1;
        hist_raddr = buf_rslot;
      end
      ST_WALK_CHK: begin
        if (cand && pend_valid && out_free) begin
          push.valid = 1'b1;
          push.value = pend;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          push.valid = 1'b1;
          push.value = pend_valid ? pend : '0;
          push.none  = !pend_valid;
          push.last  = 1'b1;
        end
      end
      ST_ZAP_BRD: begin
        buf_rd_en = 1'b1;
      end
      ST_ZAP_WR: begin
        hist_wr_en = 1'b1;
        hist_waddr = buf_rslot;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR_ALL;
      clr_idx    <= '0;
      count      <= '0;
      idx        <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLR_ALL: clr_idx <= clr_idx + SLOT_W'(1);
        ST_IDLE: begin
          if (in_valid) begin
            cur_value <= in_value;
            cur_last  <= in_end;
          end
        end
        ST_HRD: begin
          count      <= count_inc;
          idx        <= '0;
          pend_valid <= 1'b0;
        end
        ST_WALK_CHK: begin
          if (walk_go) begin
            if (cand) begin
              pend       <= buf_rvalue;
              pend_valid <= 1'b1;
            end
            idx <= last_elem ? '0 : idx + IDX_W'(1);
          end
        end
        ST_ZAP_WR: begin
          if (last_elem) begin
            idx   <= '0;
            count <= '0;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

endmodule

// ----- hdl/unique_element_filter.sv -----
// unique element filter
// input channel: one beat per element (value, end_of_set) on in_valid/in_stall;
// a beat is taken at a rising edge with in_valid high and in_stall low.
// output channel: result beats (unique_value, none_found, last_result) on
// out_valid/out_stall, held in an output register until taken.
// loading: each element passes through taking the beat, the
// reciprocal-multiply slot reduction (quotient, then remainder) and the
// histogram and buffer write; the histogram read-modify-write makes one
// access a cycle, on the memory's separate read and write ports.
// a set closes on end_of_set or when MAX_ELEMENTS elements are held; the
// emit walk then reads each buffered element (buffer, histogram, check)
// and a flush step sends the last result; a second walk then clears the
// touched histogram slots, after which the next element is taken.
// results come out in input order; the final one carries last_result, and a
// set with no unique element gives one beat with none_found set.
// reset: a clearing pass writes zero to every histogram entry, with
// in_stall held high throughout.
// out_stall freezes the output beat; the walk pauses while a new result waits.
module unique_element_filter #(
  parameter int VALUE_RANGE = uef_pkg::DEF_VALUE_RANGE,
  parameter int MAX_ELEMENTS = uef_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [uef_pkg::VALUE_W-1:0] value,
  input  logic                        end_of_set,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [uef_pkg::VALUE_W-1:0] unique_value,
  output logic                        none_found,
  output logic                        last_result
);
  import uef_pkg::*;
  `include "unique_element_filter_macros.svh"

  localparam int SLOT_W = $clog2(VALUE_RANGE);
  localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  // slot reduction unit
  logic              slot_start;
  logic              slot_done;
  logic [SLOT_W-1:0] slot;

  // histogram port
  logic              hist_rd_en;
  logic [SLOT_W-1:0] hist_raddr;
  logic [1:0]        hist_rdata;
  logic              hist_wr_en;
  logic [SLOT_W-1:0] hist_waddr;
  logic [1:0]        hist_wdata;

  // element buffer port
  logic               buf_wr_en;
  logic [IDX_W-1:0]   buf_waddr;
  logic [SLOT_W-1:0]  buf_wslot;
  logic [VALUE_W-1:0] buf_wvalue;
  logic               buf_rd_en;
  logic [IDX_W-1:0]   buf_raddr;
  logic [SLOT_W-1:0]  buf_rslot;
  logic [VALUE_W-1:0] buf_rvalue;

  // result hand-off into the output register
  push_t push;
  logic  out_free;

  uef_slot #(.VALUE_RANGE(VALUE_RANGE)) u_slot (
    .clk   (clk),
    .rst   (rst),
    .start (slot_start),
    .value (value),
    .slot  (slot),
    .done  (slot_done)
  );

  uef_hist #(.VALUE_RANGE(VALUE_RANGE)) u_hist (
    .clk   (clk),
    .rd_en (hist_rd_en),
    .raddr (hist_raddr),
    .rdata (hist_rdata),
    .wr_en (hist_wr_en),
    .waddr (hist_waddr),
    .wdata (hist_wdata)
  );

  uef_buf #(.MAX_ELEMENTS(MAX_ELEMENTS), .SLOT_W(SLOT_W)) u_buf (
    .clk    (clk),
    .wr_en  (buf_wr_en),
    .waddr  (buf_waddr),
    .wslot  (buf_wslot),
    .wvalue (buf_wvalue),
    .rd_en  (buf_rd_en),
    .raddr  (buf_raddr),
    .rslot  (buf_rslot),
    .rvalue (buf_rvalue)
  );

  uef_ctrl #(.VALUE_RANGE(VALUE_RANGE), .MAX_ELEMENTS(MAX_ELEMENTS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_value   (value),
    .in_end     (end_of_set),
    .in_stall   (in_stall),
    .slot_start (slot_start),
    .slot_done  (slot_done),
    .slot       (slot),
    .hist_rd_en (hist_rd_en),
    .hist_raddr (hist_raddr),
    .hist_rdata (hist_rdata),
    .hist_wr_en (hist_wr_en),
    .hist_waddr (hist_waddr),
    .hist_wdata (hist_wdata),
    .buf_wr_en  (buf_wr_en),
    .buf_waddr  (buf_waddr),
    .buf_wslot  (buf_wslot),
    .buf_wvalue (buf_wvalue),
    .buf_rd_en  (buf_rd_en),
    .buf_raddr  (buf_raddr),
    .buf_rslot  (buf_rslot),
    .buf_rvalue (buf_rvalue),
    .out_free   (out_free),
    .push       (push)
  );

  // output register: free when empty or its beat leaves this cycle
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      unique_value <= push.value;
      none_found   <= push.none;
      last_result  <= push.last;
    end
  end

  // a held beat is never overwritten
  `UEF_ASSERT_IMP(a_no_overwrite, clk, rst, push.valid, out_free)
  // a taken element always starts a busy stretch
  `UEF_ASSERT_NXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall)
  // the empty-set marker is alone and carries a zero value
  `UEF_ASSERT_IMP(a_none_is_last, clk, rst, out_valid && none_found,
                  last_result && (unique_value == '0))

endmodule
